@@ rtl/core/idlex_pkg.sv @@
// Shared types and constants for the identifier lexer with line/column tracking.
// Used by idlex_scan, idlex_outq, the top level and the checker.
package idlex_pkg;

    // Field widths
    localparam int LINE_W      = 24;
    localparam int COL_W       = 16;
    localparam int TOK_LEN_W   = 8;
    localparam int BYTE_W      = 8;

    // Identifier length counter; saturates at MAX_IDENT_LEN
    localparam int MAX_IDENT_LEN = 255;
    localparam int ID_LEN_W      = $clog2(MAX_IDENT_LEN + 1);

    localparam logic [LINE_W-1:0]   LINE_MAX = '1;
    localparam logic [COL_W-1:0]    COL_MAX  = '1;
    localparam logic [ID_LEN_W-1:0] ID_LEN_MAX = ID_LEN_W'(MAX_IDENT_LEN);

    // Byte codes
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [BYTE_W-1:0] UTF8_TOP_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF8_CONT     = 8'h80;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_IDENT = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // Scanner modes, one-hot
    typedef enum logic [3:0] {
        MODE_SKIP    = 4'b0001,
        MODE_COMMENT = 4'b0010,
        MODE_IDENT   = 4'b0100,
        MODE_HALT    = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } t_pos;

    typedef struct packed {
        t_kind                kind;
        logic [LINE_W-1:0]    line;
        logic [COL_W-1:0]     col;
        logic [TOK_LEN_W-1:0] len;
        logic                 last;
    } t_result;

    // Results produced by one accepted item (count is 0, 1 or 2)
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

@@ rtl/core/idlex_scan.sv @@
// Scanner state and per-byte decode: updates position/mode on each item and
// forms up to two results. Depends on idlex_pkg.
module idlex_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [idlex_pkg::BYTE_W-1:0] i_source_byte,
    input  logic                        i_final_byte,
    output idlex_pkg::t_push            o_push
);

    idlex_pkg::t_mode                    r_mode, n_mode;
    idlex_pkg::t_pos                     r_pos, n_pos;
    idlex_pkg::t_pos                     r_start, n_start;
    logic [idlex_pkg::ID_LEN_W-1:0]      r_len, n_len;

    logic                                is_blank, is_start, is_name;
    idlex_pkg::t_pos                     pos_adv;
    idlex_pkg::t_result                  res [2];
    logic [1:0]                          cnt;
    logic                                err;
    logic                                do_skip;

    // Position after consuming a byte: newline bumps line and resets column to 1, other
    // non-continuation bytes bump column; line and column saturate.
    function automatic idlex_pkg::t_pos advance(idlex_pkg::t_pos p,
                                               logic [idlex_pkg::BYTE_W-1:0] b);
        idlex_pkg::t_pos q;
        q = p;
        if (b == idlex_pkg::CH_LF) begin
            if (p.line != idlex_pkg::LINE_MAX) q.line = p.line + 1'b1;
            q.col = idlex_pkg::COL_W'(1);
        end else if ((b & idlex_pkg::UTF8_TOP_MASK) != idlex_pkg::UTF8_CONT) begin
            if (p.col != idlex_pkg::COL_MAX) q.col = p.col + 1'b1;
        end
        return q;
    endfunction

    // Reported length saturates at the 8-bit field
    function automatic logic [idlex_pkg::TOK_LEN_W-1:0] rep_len(
            logic [idlex_pkg::ID_LEN_W-1:0] v);
        if (32'(v) > 32'd255) return '1;
        return idlex_pkg::TOK_LEN_W'(v);
    endfunction

    function automatic idlex_pkg::t_result mk_res(idlex_pkg::t_kind k,
                                                 idlex_pkg::t_pos p,
                                                 logic [idlex_pkg::TOK_LEN_W-1:0] l);
        idlex_pkg::t_result r;
        r.kind = k;
        r.line = p.line;
        r.col  = p.col;
        r.len  = l;
        r.last = 1'b0;
        return r;
    endfunction

    // Byte classes
    assign is_blank = (i_source_byte == idlex_pkg::CH_SPACE) ||
                      (i_source_byte == idlex_pkg::CH_TAB) ||
                      (i_source_byte == idlex_pkg::CH_CR) ||
                      (i_source_byte == idlex_pkg::CH_LF);
    assign is_start = (i_source_byte inside {[8'h61:8'h7A], [8'h41:8'h5A]}) ||
                      (i_source_byte == idlex_pkg::CH_UNDER);
    assign is_name  = is_start || (i_source_byte inside {[8'h30:8'h39]});
    assign pos_adv  = advance(r_pos, i_source_byte);

    // Next-state and result formation
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        res[0]  = '0;
        res[1]  = '0;
        cnt     = 2'd0;
        err     = 1'b0;
        do_skip = 1'b0;

        case (r_mode)
            idlex_pkg::MODE_SKIP: begin
                do_skip = 1'b1;
            end
            idlex_pkg::MODE_COMMENT: begin
                n_pos = pos_adv;
                if (i_source_byte == idlex_pkg::CH_LF) n_mode = idlex_pkg::MODE_SKIP;
            end
            idlex_pkg::MODE_IDENT: begin
                if (is_name) begin
                    if (r_len != idlex_pkg::ID_LEN_MAX) n_len = r_len + 1'b1;
                    n_pos = pos_adv;
                end else begin
                    // terminating byte emits the token, then is scanned as a blank-skip byte
                    res[0]  = mk_res(idlex_pkg::KIND_IDENT, r_start, rep_len(r_len));
                    cnt     = 2'd1;
                    n_len   = '0;
                    n_mode  = idlex_pkg::MODE_SKIP;
                    do_skip = 1'b1;
                end
            end
            default: ;
        endcase

        // Byte where a name may start
        if (do_skip) begin
            if (is_blank) begin
                n_pos  = pos_adv;
                n_mode = idlex_pkg::MODE_SKIP;
            end else if (i_source_byte == idlex_pkg::CH_HASH) begin
                n_pos  = pos_adv;
                n_mode = idlex_pkg::MODE_COMMENT;
            end else if (is_start) begin
                n_start = r_pos;
                n_len   = idlex_pkg::ID_LEN_W'(1);
                n_pos   = pos_adv;
                n_mode  = idlex_pkg::MODE_IDENT;
            end else begin
                res[cnt[0]] = mk_res(idlex_pkg::KIND_ERROR, r_pos, '0);
                cnt         = cnt + 2'd1;
                n_mode      = idlex_pkg::MODE_HALT;
                err         = 1'b1;
            end
        end

        // End of source: flush open identifier, emit end unless this byte raised an error, return to reset state
        if (i_final_byte) begin
            if (n_mode == idlex_pkg::MODE_IDENT) begin
                res[cnt[0]] = mk_res(idlex_pkg::KIND_IDENT, n_start, rep_len(n_len));
                cnt         = cnt + 2'd1;
            end
            if (!err) begin
                res[cnt[0]] = mk_res(idlex_pkg::KIND_END, n_pos, '0);
                cnt         = cnt + 2'd1;
            end
            n_mode     = idlex_pkg::MODE_SKIP;
            n_pos.line = idlex_pkg::LINE_W'(1);
            n_pos.col  = idlex_pkg::COL_W'(1);
            n_start    = n_pos;
            n_len      = '0;
        end

        // Flag the final result of this item
        if (cnt == 2'd2) res[1].last = 1'b1;
        else if (cnt == 2'd1) res[0].last = 1'b1;
    end

    assign o_push.count = i_take ? cnt : 2'd0;
    assign o_push.r0    = res[0];
    assign o_push.r1    = res[1];

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= idlex_pkg::MODE_SKIP;
            r_pos.line   <= idlex_pkg::LINE_W'(1);
            r_pos.col    <= idlex_pkg::COL_W'(1);
            r_start.line <= idlex_pkg::LINE_W'(1);
            r_start.col  <= idlex_pkg::COL_W'(1);
            r_len        <= '0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
        end
    end

endmodule

@@ rtl/core/idlex_outq.sv @@
// Four-entry result queue: takes up to two results per cycle, hands out one while i_ready is high.
// Input side is ready while at least two entries are free. Depends on idlex_pkg.
module idlex_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  idlex_pkg::t_push   i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output idlex_pkg::t_result o_result
);

    idlex_pkg::t_result r_q [4];
    logic [1:0]         r_wr, n_wr;
    logic [1:0]         r_rd, n_rd;
    logic [2:0]         r_cnt, n_cnt;
    logic               pop;

    assign o_room   = (r_cnt <= 3'd2);
    assign o_valid  = (r_cnt != 3'd0);
    assign o_result = r_q[r_rd];
    assign pop      = o_valid && i_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr  = r_wr + i_push.count;
        n_rd  = r_rd + {1'b0, pop};
        n_cnt = r_cnt + {1'b0, i_push.count} - {2'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry writes
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_q[r_wr] <= i_push.r0;
        if (i_push.count == 2'd2) r_q[r_wr + 2'd1] <= i_push.r1;
    end

endmodule

@@ rtl/core/identifier_lexer_line_column.sv @@
// Identifier lexer with line/column tracking: top level.
// A result enters the result queue when its byte is accepted and is offered once
// earlier results have left. Throughput: one byte per cycle while o_ready is high;
// a byte's two results leave in turn, and the four-entry result queue takes up the slack.
// Reset (synchronous, active low): line 1, column 1, skipping blanks, queue empty.
module identifier_lexer_line_column (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [idlex_pkg::BYTE_W-1:0]    i_source_byte,
    input  logic                            i_final_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_kind,
    output logic [idlex_pkg::LINE_W-1:0]    o_line_number,
    output logic [idlex_pkg::COL_W-1:0]     o_column_number,
    output logic [idlex_pkg::TOK_LEN_W-1:0] o_token_length,
    output logic                            o_last_of_run
);

    idlex_pkg::t_push   push;
    idlex_pkg::t_result result;
    logic               room;
    logic               take;

    assign o_ready = room;
    assign take    = i_valid && room;

    // Byte decode and scanner state
    idlex_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_source_byte (i_source_byte),
        .i_final_byte  (i_final_byte),
        .o_push        (push)
    );

    // Result queue toward the output channel
    idlex_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_kind          = result.kind;
    assign o_line_number   = result.line;
    assign o_column_number = result.col;
    assign o_token_length  = result.len;
    assign o_last_of_run   = result.last;

endmodule

@@ rtl/core/idlex_chk.sv @@
// Port-level checker for the identifier lexer, bound to the top level.
// Depends on idlex_pkg.
module idlex_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [1:0]                      o_kind,
    input logic [idlex_pkg::LINE_W-1:0]    o_line_number,
    input logic [idlex_pkg::COL_W-1:0]     o_column_number,
    input logic [idlex_pkg::TOK_LEN_W-1:0] o_token_length,
    input logic                            o_last_of_run
);

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) &&
        $stable(o_line_number) && $stable(o_column_number) &&
        $stable(o_token_length) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // End closes an item's results and carries no length
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == idlex_pkg::KIND_END |-> o_last_of_run && o_token_length == '0)
        else $error("end result malformed");

    // Identifiers are never empty; errors carry no length
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind == idlex_pkg::KIND_IDENT && o_token_length != '0) ||
                    (o_kind == idlex_pkg::KIND_ERROR && o_token_length == '0) ||
                    (o_kind == idlex_pkg::KIND_END))
        else $error("bad kind or length");

    // Positions are one-based
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_line_number != '0 && o_column_number != '0)
        else $error("zero position");

endmodule

bind identifier_lexer_line_column idlex_chk u_idlex_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_kind          (o_kind),
    .o_line_number   (o_line_number),
    .o_column_number (o_column_number),
    .o_token_length  (o_token_length),
    .o_last_of_run   (o_last_of_run)
);
